// ===== sv/ubxfd_pkg.sv =====
// Shared types and constants for the UBX frame decoder.
`timescale 1ns / 1ps
package ubxfd_pkg;

  localparam int MaxPayloadDefault = 512;

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;

  localparam int PosWidth = 17;

  typedef enum logic [2:0] {
    ST_SYNCING   = 3'd0,
    ST_DECODING  = 3'd1,
    ST_DECODED   = 3'd2,
    ST_CKERROR   = 3'd3,
    ST_UNHANDLED = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
  } result_t;

endpackage

// ===== sv/ubxfd_parser.sv =====
// Frame parse state, Fletcher checksum and per-byte result.
`timescale 1ns / 1ps
module ubxfd_parser #(
  parameter int MAX_PAYLOAD = ubxfd_pkg::MaxPayloadDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  input  logic                storage_ready,
  output ubxfd_pkg::result_t  result
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  logic [ubxfd_pkg::PosWidth-1:0] pos_r, pos_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  ck_low_r, ck_low_nxt;
  logic        keep_r, keep_nxt;

  logic [ubxfd_pkg::PosWidth-1:0] off;
  logic [ubxfd_pkg::PosWidth-1:0] len_ext;
  logic [ubxfd_pkg::PosWidth-1:0] sum_end;
  logic [15:0] len_full;

  always_comb begin
    len_ext  = {1'b0, len_r};
    sum_end  = len_ext + ubxfd_pkg::PosWidth'(6);
    off      = pos_r - ubxfd_pkg::PosWidth'(6);
    len_full = {rx_byte, len_r[7:0]};

    pos_nxt    = pos_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    ck_low_nxt = ck_low_r;
    keep_nxt   = keep_r;

    result               = '0;
    result.status        = ubxfd_pkg::ST_DECODING;

    if (pos_r >= ubxfd_pkg::PosWidth'(2) && pos_r < sum_end) begin
      sum_a_nxt = sum_a_r + rx_byte;
      sum_b_nxt = sum_b_r + sum_a_nxt;
    end

    priority if (pos_r == ubxfd_pkg::PosWidth'(0)) begin
      if (rx_byte != ubxfd_pkg::SyncFirst) begin
        result.status = ubxfd_pkg::ST_SYNCING;
      end else begin
        pos_nxt    = ubxfd_pkg::PosWidth'(1);
        sum_a_nxt  = '0;
        sum_b_nxt  = '0;
        class_nxt  = '0;
        id_nxt     = '0;
        len_nxt    = '0;
        ck_low_nxt = '0;
        keep_nxt   = 1'b0;
      end
    end else if (pos_r == ubxfd_pkg::PosWidth'(1)) begin
      if (rx_byte != ubxfd_pkg::SyncSecond) begin
        pos_nxt       = '0;
        result.status = ubxfd_pkg::ST_SYNCING;
      end else begin
        keep_nxt = storage_ready;
        pos_nxt  = ubxfd_pkg::PosWidth'(2);
      end
    end else if (pos_r == ubxfd_pkg::PosWidth'(2)) begin
      class_nxt = rx_byte;
      pos_nxt   = ubxfd_pkg::PosWidth'(3);
    end else if (pos_r == ubxfd_pkg::PosWidth'(3)) begin
      id_nxt  = rx_byte;
      pos_nxt = ubxfd_pkg::PosWidth'(4);
    end else if (pos_r == ubxfd_pkg::PosWidth'(4)) begin
      len_nxt = {8'h00, rx_byte};
      pos_nxt = ubxfd_pkg::PosWidth'(5);
    end else if (pos_r == ubxfd_pkg::PosWidth'(5)) begin
      len_nxt = len_full;
      if (len_full > MaxLen) begin
        keep_nxt = 1'b0;
      end
      pos_nxt = ubxfd_pkg::PosWidth'(6);
    end else if (off < len_ext) begin
      if (keep_r) begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
        result.payload_index = off[8:0];
      end
      pos_nxt = pos_r + ubxfd_pkg::PosWidth'(1);
    end else if (off == len_ext) begin
      ck_low_nxt = rx_byte;
      pos_nxt    = pos_r + ubxfd_pkg::PosWidth'(1);
    end else begin
      pos_nxt = '0;
      priority if (ck_low_r != sum_a_r || rx_byte != sum_b_r) begin
        result.status = ubxfd_pkg::ST_CKERROR;
      end else if (keep_r) begin
        result.status     = ubxfd_pkg::ST_DECODED;
        result.msg_class  = class_r;
        result.msg_id     = id_r;
        result.msg_length = len_r;
      end else begin
        result.status = ubxfd_pkg::ST_UNHANDLED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      class_r  <= '0;
      id_r     <= '0;
      len_r    <= '0;
      ck_low_r <= '0;
      keep_r   <= 1'b0;
    end else if (fire) begin
      pos_r    <= pos_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      ck_low_r <= ck_low_nxt;
      keep_r   <= keep_nxt;
    end
  end

endmodule

// ===== sv/ubxfd_out_buf.sv =====
// Two-entry result buffer between the parser and the result channel.
`timescale 1ns / 1ps
module ubxfd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ubxfd_pkg::result_t  push_data,
  output logic                can_push,
  input  logic                pop_ready,
  output logic                head_valid,
  output ubxfd_pkg::result_t  head_data
);

  logic [1:0]         cnt_r, cnt_nxt;
  ubxfd_pkg::result_t ent0_r, ent0_nxt;
  ubxfd_pkg::result_t ent1_r, ent1_nxt;
  logic               pop;

  assign can_push   = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = ent0_r;
  assign pop        = head_valid && pop_ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    if (pop) begin
      if (cnt_r == 2'd2) begin
        ent0_nxt = ent1_r;
      end else if (push) begin
        ent0_nxt = push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        ent0_nxt = push_data;
      end else begin
        ent1_nxt = push_data;
      end
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/ubx_frame_decoder_unit.sv =====
// UBX frame decoder top level: byte parser feeding a two-entry result buffer.
// Takes one received byte per request and returns one status request per byte,
// sustaining one byte every cycle while the buffer is not full; each result is
// registered in the buffer. The two-entry result buffer sets this: input stays
// ready while at most one result waits; a byte parses in the cycle it arrives.
`timescale 1ns / 1ps
module ubx_frame_decoder_unit #(
  parameter int MAX_PAYLOAD = ubxfd_pkg::MaxPayloadDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_storage_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [8:0]  out_payload_index,
  output logic [7:0]  out_msg_class,
  output logic [7:0]  out_msg_id,
  output logic [15:0] out_msg_length
);

  logic               in_fire;
  ubxfd_pkg::result_t parse_res;
  ubxfd_pkg::result_t head;

  assign in_fire = in_valid && in_ready;

  ubxfd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (in_fire),
    .rx_byte       (in_rx_byte),
    .storage_ready (in_storage_ready),
    .result        (parse_res)
  );

  ubxfd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_data  (parse_res),
    .can_push   (in_ready),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head_data  (head)
  );

  assign out_status        = head.status;
  assign out_payload_valid = head.payload_valid;
  assign out_payload_byte  = head.payload_byte;
  assign out_payload_index = head.payload_index;
  assign out_msg_class     = head.msg_class;
  assign out_msg_id        = head.msg_id;
  assign out_msg_length    = head.msg_length;

`ifndef NO_ASSERTIONS
  a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_status == ubxfd_pkg::ST_DECODING)
    else $error("payload byte reported outside decoding status");

  a_header_only_decoded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ubxfd_pkg::ST_DECODED |->
      out_msg_class == 8'h00 && out_msg_id == 8'h00 && out_msg_length == 16'h0000)
    else $error("frame header reported without decoded status");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !$past(out_ready && out_valid) || $past(!rst_n) || out_valid)
    else $error("input stalled with no pending result");
`endif

endmodule

// ===== dv/tb_ubx_frame_decoder_unit.sv =====
// Self-checking testbench for the UBX frame decoder: directed frames, long frames, random traffic.
`timescale 1ns / 1ps
module tb_ubx_frame_decoder_unit;

  localparam int MAX_PAYLOAD  = ubxfd_pkg::MaxPayloadDefault;
  localparam int RANDOM_BYTES = 280;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLDOFF_CYCLES = 300;

  typedef struct {
    logic [7:0]         rx;
    logic               sr;
    bit                 pinned;
    ubxfd_pkg::result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_storage_ready = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic [8:0]  out_payload_index;
  logic [7:0]  out_msg_class;
  logic [7:0]  out_msg_id;
  logic [15:0] out_msg_length;

  ubx_frame_decoder_unit #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .in_storage_ready(in_storage_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_payload_valid(out_payload_valid),
    .out_payload_byte(out_payload_byte),
    .out_payload_index(out_payload_index),
    .out_msg_class(out_msg_class),
    .out_msg_id(out_msg_id),
    .out_msg_length(out_msg_length)
  );

  always #10 clk = ~clk;

  // decoder state mirror
  logic [16:0] frame_pos = '0;
  logic [7:0]  run_a = '0;
  logic [7:0]  run_b = '0;
  logic [7:0]  hdr_class = '0;
  logic [7:0]  hdr_id = '0;
  logic [15:0] hdr_len = '0;
  logic [7:0]  ck_low = '0;
  logic        kept = 1'b0;

  ubxfd_pkg::result_t pending_results[$];
  stim_row_t          pin_q[$];
  stim_row_t          directed[$];

  int  mismatches = 0;
  int  results_checked = 0;
  int  bytes_sent = 0;
  int  burst_left = 0;
  int  cycle_count = 0;
  int  holdoff_left = 0;
  bit  want_holdoff = 1'b0;
  logic [15:0] stall_mask = '0;
  logic [3:0]  stall_phase = '0;

  function automatic ubxfd_pkg::result_t parse_byte(input logic [7:0] rx, input logic sr);
    ubxfd_pkg::result_t r;
    int unsigned off;
    r = '0;
    r.status = ubxfd_pkg::ST_DECODING;
    if (frame_pos >= 2 && int'(frame_pos) < 6 + int'(hdr_len)) begin
      run_a = run_a + rx;
      run_b = run_b + run_a;
    end
    case (frame_pos)
      17'd0: begin
        if (rx != ubxfd_pkg::SyncFirst) begin
          r.status = ubxfd_pkg::ST_SYNCING;
        end else begin
          run_a = '0;
          run_b = '0;
          hdr_class = '0;
          hdr_id = '0;
          hdr_len = '0;
          ck_low = '0;
          kept = 1'b0;
          frame_pos = 17'd1;
        end
      end
      17'd1: begin
        if (rx != ubxfd_pkg::SyncSecond) begin
          frame_pos = 17'd0;
          r.status = ubxfd_pkg::ST_SYNCING;
        end else begin
          kept = sr;
          frame_pos = 17'd2;
        end
      end
      17'd2: begin
        hdr_class = rx;
        frame_pos = 17'd3;
      end
      17'd3: begin
        hdr_id = rx;
        frame_pos = 17'd4;
      end
      17'd4: begin
        hdr_len = {8'h00, rx};
        frame_pos = 17'd5;
      end
      17'd5: begin
        hdr_len[15:8] = rx;
        if (int'(hdr_len) > MAX_PAYLOAD) kept = 1'b0;
        frame_pos = 17'd6;
      end
      default: begin
        off = int'(frame_pos) - 6;
        if (off < int'(hdr_len)) begin
          if (kept) begin
            r.payload_valid = 1'b1;
            r.payload_byte = rx;
            r.payload_index = off[8:0];
          end
          frame_pos = frame_pos + 17'd1;
        end else if (off == int'(hdr_len)) begin
          ck_low = rx;
          frame_pos = frame_pos + 17'd1;
        end else begin
          frame_pos = 17'd0;
          if (ck_low != run_a || rx != run_b) begin
            r.status = ubxfd_pkg::ST_CKERROR;
          end else if (kept) begin
            r.status = ubxfd_pkg::ST_DECODED;
            r.msg_class = hdr_class;
            r.msg_id = hdr_id;
            r.msg_length = hdr_len;
          end else begin
            r.status = ubxfd_pkg::ST_UNHANDLED;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0h want %0h at result %0d", name, got, want,
                           results_checked));
  endtask

  always @(posedge clk) begin : scoreboard
    ubxfd_pkg::result_t want;
    stim_row_t          pin;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result with nothing pending after %0d", results_checked));
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 16'(out_status), 16'(want.status));
          compare_field("payload_valid", 16'(out_payload_valid), 16'(want.payload_valid));
          compare_field("payload_byte", 16'(out_payload_byte), 16'(want.payload_byte));
          compare_field("payload_index", 16'(out_payload_index), 16'(want.payload_index));
          compare_field("msg_class", 16'(out_msg_class), 16'(want.msg_class));
          compare_field("msg_id", 16'(out_msg_id), 16'(want.msg_id));
          compare_field("msg_length", out_msg_length, want.msg_length);
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        want = parse_byte(in_rx_byte, in_storage_ready);
        pin = pin_q.pop_front();
        if (pin.pinned) want = pin.res;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (want_holdoff) begin
      holdoff_left = HOLDOFF_CYCLES;
      want_holdoff = 1'b0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      if (stall_phase == 4'd0)
        stall_mask = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom & $urandom);
      out_ready <= !stall_mask[stall_phase];
      stall_phase = stall_phase + 4'd1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic offer(input logic [7:0] rx, input logic sr, input bit pinned = 1'b0,
                       input ubxfd_pkg::result_t res = '0);
    stim_row_t row;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 256)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    row.rx = rx;
    row.sr = sr;
    row.pinned = pinned;
    row.res = res;
    pin_q.push_back(row);
    in_valid <= 1'b1;
    in_rx_byte <= rx;
    in_storage_ready <= sr;
    bytes_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_frame(input int len, input logic sr, input bit corrupt);
    logic [7:0] body[$];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    ck_a = '0;
    ck_b = '0;
    body = {8'($urandom), 8'($urandom), len[7:0], len[15:8]};
    repeat (len) body.push_back(8'($urandom));
    foreach (body[k]) begin
      ck_a = ck_a + body[k];
      ck_b = ck_b + ck_a;
    end
    if (corrupt) begin
      if ($urandom_range(0, 1)) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      else ck_b = ck_b ^ 8'($urandom_range(1, 255));
    end
    offer(ubxfd_pkg::SyncFirst, 1'($urandom_range(0, 1)));
    offer(ubxfd_pkg::SyncSecond, sr);
    foreach (body[k]) offer(body[k], 1'($urandom_range(0, 1)));
    offer(ck_a, 1'($urandom_range(0, 1)));
    offer(ck_b, 1'($urandom_range(0, 1)));
  endtask

  function automatic ubxfd_pkg::result_t bare(input ubxfd_pkg::status_t s);
    ubxfd_pkg::result_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] rx, input logic sr, input bit pinned,
                         input ubxfd_pkg::result_t res);
    stim_row_t row;
    row.rx = rx;
    row.sr = sr;
    row.pinned = pinned;
    row.res = res;
    directed.push_back(row);
  endtask

  initial begin
    int base;
    int pick;
    int sel;
    int len;
    bit holdoff_done;
    bit paused;
    logic [7:0] v;

    add_row(8'h00, 1'b0, 1'b1, bare(ubxfd_pkg::ST_SYNCING));
    add_row(8'hFF, 1'b1, 1'b1, bare(ubxfd_pkg::ST_SYNCING));
    add_row(ubxfd_pkg::SyncFirst, 1'b1, 1'b1, bare(ubxfd_pkg::ST_DECODING));
    add_row(ubxfd_pkg::SyncFirst, 1'b0, 1'b1, bare(ubxfd_pkg::ST_SYNCING));
    add_row(ubxfd_pkg::SyncFirst, 1'b0, 1'b0, '0);
    add_row(ubxfd_pkg::SyncSecond, 1'b1, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h02, 1'b1, 1'b0, '0);
    add_row(8'h02, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1,
            '{ubxfd_pkg::ST_DECODING, 1'b1, 8'hFF, 9'd0, 8'h00, 8'h00, 16'h0000});
    add_row(8'h00, 1'b1, 1'b1,
            '{ubxfd_pkg::ST_DECODING, 1'b1, 8'h00, 9'd1, 8'h00, 8'h00, 16'h0000});
    add_row(8'h04, 1'b0, 1'b0, '0);
    add_row(8'h16, 1'b1, 1'b1,
            '{ubxfd_pkg::ST_DECODED, 1'b0, 8'h00, 9'd0, 8'h01, 8'h02, 16'd2});
    add_row(ubxfd_pkg::SyncFirst, 1'b1, 1'b0, '0);
    add_row(ubxfd_pkg::SyncSecond, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFE, 1'b1, 1'b0, '0);
    add_row(8'hF9, 1'b0, 1'b1, bare(ubxfd_pkg::ST_UNHANDLED));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[k])
      offer(directed[k].rx, directed[k].sr, directed[k].pinned, directed[k].res);
    drain();

    send_frame(MAX_PAYLOAD, 1'b1, 1'b0);
    send_frame(MAX_PAYLOAD + 1, 1'b1, 1'b0);
    send_frame(0, 1'b1, 1'b1);
    drain();

    holdoff_done = 1'b0;
    paused = 1'b0;
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) len = $urandom_range(0, 8);
        else if (sel < 97) len = $urandom_range(9, 40);
        else if (sel < 99) len = $urandom_range(500, MAX_PAYLOAD);
        else len = $urandom_range(MAX_PAYLOAD + 1, 600);
        send_frame(len, $urandom_range(0, 7) != 0, $urandom_range(0, 6) == 0);
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 6)) begin
          do v = 8'($urandom); while (v == ubxfd_pkg::SyncFirst);
          offer(v, 1'($urandom_range(0, 1)));
        end
      end else begin
        offer(ubxfd_pkg::SyncFirst, 1'($urandom_range(0, 1)));
        do v = 8'($urandom); while (v == ubxfd_pkg::SyncSecond);
        offer(v, 1'($urandom_range(0, 1)));
      end
      if (!holdoff_done && bytes_sent - base > 60) begin
        want_holdoff = 1'b1;
        holdoff_done = 1'b1;
      end
      if (!paused && bytes_sent - base > 150) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
